>>> hw/rtl/pixel_palette_indexer_defines.svh
// Assertion macros for the pixel palette indexer
`ifndef PIXEL_PALETTE_INDEXER_DEFINES_SVH
`define PIXEL_PALETTE_INDEXER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PPI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPI_ASSERT_SAME(label, ante, cons, msg)
`define PPI_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> hw/rtl/ppi_pkg.sv
// Shared constants, word types and control structs of the pixel palette indexer
`timescale 1ns / 1ps

package ppi_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int FRAME_WIDTH     = 320;
    localparam int FRAME_HEIGHT    = 200;

    localparam int CHAN_IN_W  = 8;
    localparam int CHAN_W     = 6;
    localparam int COLOR_W    = 3 * CHAN_W;
    localparam int INDEX_W    = 8;
    localparam int OFFSET_W   = 16;
    localparam int IDX_W      = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int USED_W     = $clog2(PALETTE_ENTRIES + 1);
    localparam int ROW_W      = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int COL_W      = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;

    typedef struct packed {
        logic [CHAN_IN_W-1:0] pixel_red;
        logic [CHAN_IN_W-1:0] pixel_green;
        logic [CHAN_IN_W-1:0] pixel_blue;
        logic                 frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [INDEX_W-1:0]  color_index;
        logic [OFFSET_W-1:0] pixel_offset;
        logic                new_entry;
        logic [CHAN_W-1:0]   dac_red;
        logic [CHAN_W-1:0]   dac_green;
        logic [CHAN_W-1:0]   dac_blue;
        logic                palette_full;
    } t_pix_out;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_ppi_cmd;

    typedef struct packed {
        logic hit;
        logic exhausted;
    } t_ppi_status;

endpackage

>>> hw/rtl/pixel_palette_indexer.sv
// Top level of the pixel palette indexer: controller, datapath and checks
// A hit ends the scan at the matching entry; a miss scans every entry in use, counted after
// any frame clear, and with an empty palette no entry is read.
// Words are taken one at a time; busy drops in the strobe cycle
// and a new word may be taken there. The scan reads one palette RAM entry per cycle.
// Reset clears the state machine, entry count and frame counters; RAM contents persist.
`timescale 1ns / 1ps
`include "pixel_palette_indexer_defines.svh"

module pixel_palette_indexer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ppi_pkg::t_pix_in  i_pixel,
    output ppi_pkg::t_pix_out o_result,
    output logic              o_strobe
);
    import ppi_pkg::*;

    t_ppi_cmd    w_cmd;
    t_ppi_status w_status;

    ppi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    ppi_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pixel  (i_pixel),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    `PPI_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
    `PPI_ASSERT_NEXT(a_finish_strobe, w_cmd.finish, o_strobe, "finish without result strobe")
    `PPI_ASSERT_SAME(a_strobe_idle, o_strobe, !busy, "result strobe while still busy")
    `PPI_ASSERT_SAME(a_full_excl, o_strobe && o_result.palette_full,
        !o_result.new_entry && (o_result.color_index == '0), "full result carries entry")

endmodule

>>> hw/rtl/ppi_ctrl.sv
// Controller state machine: accept a word, sequence the palette scan, finish
`timescale 1ns / 1ps

module ppi_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ppi_pkg::t_ppi_status i_status,
    output ppi_pkg::t_ppi_cmd    o_cmd
);
    import ppi_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_ppi_state;

    t_ppi_state r_state;
    t_ppi_state n_state;
    logic       w_done;

    assign w_done = i_status.hit || i_status.exhausted;
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/ppi_datapath.sv
// Datapath: palette RAM, scan pointer, compare, frame counters, result register
`timescale 1ns / 1ps

module ppi_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ppi_pkg::t_pix_in     i_pixel,
    input  ppi_pkg::t_ppi_cmd    i_cmd,
    output ppi_pkg::t_ppi_status o_status,
    output ppi_pkg::t_pix_out    o_result,
    output logic                 o_strobe
);
    import ppi_pkg::*;

    logic [COLOR_W-1:0]  r_palette [PALETTE_ENTRIES];
    logic [COLOR_W-1:0]  r_colour;
    logic [COLOR_W-1:0]  r_rd_data;
    logic [USED_W-1:0]   r_used;
    logic [USED_W-1:0]   r_k;
    logic [IDX_W-1:0]    r_pidx;
    logic                r_pend;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    n_row;
    logic [COL_W-1:0]    n_col;
    t_pix_out            r_result;
    t_pix_out            n_result;
    logic                r_strobe;
    logic                w_full;
    logic                w_add;
    logic                w_clear;

    assign o_status.hit       = r_pend && (r_rd_data == r_colour);
    assign o_status.exhausted = !r_pend && (r_k == r_used);
    assign w_full  = (r_used == USED_W'(PALETTE_ENTRIES));
    assign w_add   = i_cmd.finish && !o_status.hit && !w_full;
    assign w_clear = i_cmd.load && i_pixel.frame_start;

    assign o_result = r_result;
    assign o_strobe = r_strobe;

    always_comb begin
        n_row = r_row + ROW_W'(1);
        n_col = r_col;
        if (r_row == ROW_W'(FRAME_HEIGHT - 1)) begin
            n_row = '0;
            n_col = r_col + COL_W'(1);
            if (r_col == COL_W'(FRAME_WIDTH - 1)) begin
                n_col = '0;
            end
        end
    end

    always_comb begin
        n_result.pixel_offset = OFFSET_W'(r_row) * OFFSET_W'(FRAME_WIDTH) + OFFSET_W'(r_col);
        n_result.new_entry    = w_add;
        n_result.palette_full = !o_status.hit && w_full;
        n_result.dac_red      = w_add ? r_colour[COLOR_W-1 -: CHAN_W] : '0;
        n_result.dac_green    = w_add ? r_colour[2*CHAN_W-1 -: CHAN_W] : '0;
        n_result.dac_blue     = w_add ? r_colour[CHAN_W-1:0] : '0;
        if (o_status.hit) begin
            n_result.color_index = INDEX_W'(r_pidx);
        end else if (w_full) begin
            n_result.color_index = '0;
        end else begin
            n_result.color_index = INDEX_W'(r_used);
        end
    end

    // palette RAM: one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && (r_k != r_used)) begin
            r_rd_data <= r_palette[r_k[IDX_W-1:0]];
        end
        if (w_add) begin
            r_palette[r_used[IDX_W-1:0]] <= r_colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_colour <= {i_pixel.pixel_red[CHAN_IN_W-1 -: CHAN_W],
                         i_pixel.pixel_green[CHAN_IN_W-1 -: CHAN_W],
                         i_pixel.pixel_blue[CHAN_IN_W-1 -: CHAN_W]};
        end
        if (i_cmd.scan) begin
            r_pidx <= r_k[IDX_W-1:0];
        end
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_k      <= '0;
            r_pend   <= 1'b0;
            r_row    <= '0;
            r_col    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
            if (i_cmd.load) begin
                r_k    <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan) begin
                if (r_k != r_used) begin
                    r_k    <= r_k + USED_W'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
            end
            if (w_clear) begin
                r_used <= '0;
                r_row  <= '0;
                r_col  <= '0;
            end else if (i_cmd.finish) begin
                r_row <= n_row;
                r_col <= n_col;
                if (w_add) begin
                    r_used <= r_used + USED_W'(1);
                end
            end
        end
    end

endmodule
